// File: hw/rtl/hlpc_pkg.sv
// Shared types, color constants and lores palette for the pixel colorizer.
// No dependencies; imported by hlpc_color, the top level and the testbench.
package hlpc_pkg;

  localparam int NumPix = 7;

  typedef logic [31:0] argb_t;
  typedef argb_t [NumPix-1:0] pix_row_t;

  typedef enum logic {
    REG_HIRES_SELECT = 1'b0,
    REG_MIXED_MODE   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic hires_select;
    logic mixed_mode;
  } mode_t;

  localparam argb_t ArgbBlack  = 32'hFF000000;
  localparam argb_t ArgbWhite  = 32'hFFFFFFFF;
  localparam argb_t ArgbPurple = 32'hFFFD44FF;
  localparam argb_t ArgbGreen  = 32'hFF3CF514;
  localparam argb_t ArgbBlue   = 32'hFFFDCF14;
  localparam argb_t ArgbOrange = 32'hFF3C6AFF;

  localparam logic [5:0] LastColumn = 6'd39;
  localparam logic [7:0] TextLine   = 8'd160;

  function automatic argb_t lores_color(input logic [3:0] nib);
    argb_t c;
    unique case (nib)
      4'h0: c = 32'hFF000000;
      4'h1: c = 32'hFF601EE3;
      4'h2: c = 32'hFFCB2525;
      4'h3: c = 32'hFFFD44FF;
      4'h4: c = 32'hFF60A300;
      4'h5: c = 32'hFF9C9C9C;
      4'h6: c = 32'hFFFDCF14;
      4'h7: c = 32'hFFFFC3D0;
      4'h8: c = 32'hFF037260;
      4'h9: c = 32'hFF3C6AFF;
      4'hA: c = 32'hFF9C9C9C;
      4'hB: c = 32'hFFD0A0FF;
      4'hC: c = 32'hFF3CF514;
      4'hD: c = 32'hFF8DDDD0;
      4'hE: c = 32'hFFD0FF72;
      default: c = 32'hFFFFFFFF;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/hires_lores_pixel_colorizer_unit.sv
// Top level of the pixel colorizer: mode registers, input and result registers.
// Depends on hlpc_pkg and hlpc_color.
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------------
//  input   | start, busy       | cur_byte, prev_byte, next_byte, column, scanline
//  result  | done (strobe)     | color0..color6, first_x, line_y, drawn
//  config  | cfg_we            | cfg_index, cfg_data
//
// One word accepted per cycle; its result strobes on done once it has passed
// the input register, then the result register after the coloring logic.
// rst is synchronous; busy is high only while rst is held.
// The receiver takes every result as it comes.
module hires_lores_pixel_colorizer_unit
  import hlpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic [7:0]  cur_byte,
  input  logic [7:0]  prev_byte,
  input  logic [7:0]  next_byte,
  input  logic [5:0]  column,
  input  logic [7:0]  scanline,
  output logic        done,
  output logic [31:0] color0,
  output logic [31:0] color1,
  output logic [31:0] color2,
  output logic [31:0] color3,
  output logic [31:0] color4,
  output logic [31:0] color5,
  output logic [31:0] color6,
  output logic [8:0]  first_x,
  output logic [7:0]  line_y,
  output logic        drawn
);

  mode_t      mode;
  logic       in_valid;
  logic [7:0] in_cur;
  logic [7:0] in_prev;
  logic [7:0] in_next;
  logic [5:0] in_column;
  logic [7:0] in_line;
  pix_row_t   colors_c;
  pix_row_t   colors;
  logic [8:0] first_x_c;
  logic       drawn_c;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_HIRES_SELECT: mode.hires_select <= cfg_data;
        REG_MIXED_MODE:   mode.mixed_mode   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_cur    <= cur_byte;
      in_prev   <= prev_byte;
      in_next   <= next_byte;
      in_column <= column;
      in_line   <= scanline;
    end
  end

  hlpc_color u_color (
    .cur_byte  (in_cur),
    .prev_byte (in_prev),
    .next_byte (in_next),
    .column    (in_column),
    .scanline  (in_line),
    .mode      (mode),
    .colors    (colors_c),
    .first_x   (first_x_c),
    .drawn     (drawn_c)
  );

  always_ff @(posedge clk) begin
    if (in_valid) begin
      colors  <= colors_c;
      first_x <= first_x_c;
      line_y  <= in_line;
      drawn   <= drawn_c;
    end
  end

  assign color0 = colors[0];
  assign color1 = colors[1];
  assign color2 = colors[2];
  assign color3 = colors[3];
  assign color4 = colors[4];
  assign color5 = colors[5];
  assign color6 = colors[6];

`ifndef SYNTHESIS
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result word without accepted input");

  a_line_tracks_input: assert property (@(posedge clk) disable iff (rst)
    done |-> line_y == $past(scanline, 2))
    else $error("line_y does not match accepted scanline");

  a_text_area_blank: assert property (@(posedge clk) disable iff (rst)
    (done && !drawn) |-> (color0 == '0 && color3 == '0 && color6 == '0))
    else $error("text area pixels not blank");

  a_first_x_range: assert property (@(posedge clk) disable iff (rst)
    done |-> first_x <= 9'd441)
    else $error("first_x out of range");
`endif

endmodule

// File: hw/rtl/hlpc_color.sv
// Combinational coloring of one graphics byte into seven ARGB pixels.
// Depends on hlpc_pkg.
module hlpc_color
  import hlpc_pkg::*;
(
  input  logic [7:0] cur_byte,
  input  logic [7:0] prev_byte,
  input  logic [7:0] next_byte,
  input  logic [5:0] column,
  input  logic [7:0] scanline,
  input  mode_t      mode,
  output pix_row_t   colors,
  output logic [8:0] first_x,
  output logic       drawn
);

  logic [NumPix+1:0] ext;
  argb_t             lores_c;

  // neighbors outside the row read as zero
  assign ext = {(column < LastColumn) & next_byte[0], cur_byte[NumPix-1:0],
                (column != 6'd0) & prev_byte[6]};

  assign lores_c = lores_color(scanline[2] ? cur_byte[7:4] : cur_byte[3:0]);
  assign drawn   = !(mode.mixed_mode && scanline >= TextLine);
  assign first_x = {column, 3'b000} - {3'b000, column};

  always_comb begin
    for (int i = 0; i < NumPix; i++) begin
      if (!drawn) begin
        colors[i] = '0;
      end else if (!mode.hires_select) begin
        colors[i] = lores_c;
      end else if (!ext[i+1]) begin
        colors[i] = ArgbBlack;
      end else if (ext[i] || ext[i+2]) begin
        colors[i] = ArgbWhite;
      end else begin
        // x parity is column parity xor pixel index parity
        unique case ({cur_byte[7], column[0] ^ (i % 2 == 1)})
          2'b00: colors[i] = ArgbPurple;
          2'b01: colors[i] = ArgbGreen;
          2'b10: colors[i] = ArgbBlue;
          default: colors[i] = ArgbOrange;
        endcase
      end
    end
  end

endmodule

// File: verif/hires_lores_pixel_colorizer_unit_tb.sv
// Testbench for hires_lores_pixel_colorizer_unit: queued directed and random words
// are checked against a built-in color predictor. Depends on hlpc_pkg and the RTL.
`timescale 1ns / 1ps

module hires_lores_pixel_colorizer_unit_tb;
  import hlpc_pkg::*;

  localparam int DrainCycles   = 6;
  localparam int WatchdogLimit = 5000;

  localparam argb_t LoresPalette [16] = '{
    32'hFF000000, 32'hFF601EE3, 32'hFFCB2525, 32'hFFFD44FF,
    32'hFF60A300, 32'hFF9C9C9C, 32'hFFFDCF14, 32'hFFFFC3D0,
    32'hFF037260, 32'hFF3C6AFF, 32'hFF9C9C9C, 32'hFFD0A0FF,
    32'hFF3CF514, 32'hFF8DDDD0, 32'hFFD0FF72, 32'hFFFFFFFF
  };

  typedef enum logic {
    KIND_PIXEL,
    KIND_CONFIG
  } word_kind_t;

  typedef struct {
    word_kind_t  kind;
    logic [7:0]  cur_byte;
    logic [7:0]  prev_byte;
    logic [7:0]  next_byte;
    logic [5:0]  column;
    logic [7:0]  scanline;
    reg_index_t  cfg_index;
    logic        cfg_data;
    int          idle_pct;
  } source_word_t;

  typedef struct {
    pix_row_t    colors;
    logic [8:0]  first_x;
    logic [7:0]  line_y;
    logic        drawn;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_data = 1'b0;
  logic [7:0]  cur_byte = '0;
  logic [7:0]  prev_byte = '0;
  logic [7:0]  next_byte = '0;
  logic [5:0]  column = '0;
  logic [7:0]  scanline = '0;
  logic        done;
  logic [31:0] color0, color1, color2, color3, color4, color5, color6;
  logic [8:0]  first_x;
  logic [7:0]  line_y;
  logic        drawn;

  source_word_t  pending_words[$];
  pixel_result_t expected_pixels[$];
  mode_t         active_mode = '0;
  int            fail_count = 0;
  int            quiet_cycles = 0;
  int            gen_idle_pct = 0;
  source_word_t  head_word;
  logic          send_pixel;
  logic          send_cfg;

  hires_lores_pixel_colorizer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cur_byte  (cur_byte),
    .prev_byte (prev_byte),
    .next_byte (next_byte),
    .column    (column),
    .scanline  (scanline),
    .done      (done),
    .color0    (color0),
    .color1    (color1),
    .color2    (color2),
    .color3    (color3),
    .color4    (color4),
    .color5    (color5),
    .color6    (color6),
    .first_x   (first_x),
    .line_y    (line_y),
    .drawn     (drawn)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pixel_result_t colorize(source_word_t w, mode_t m);
    pixel_result_t r;
    logic [8:0]    run;
    logic [8:0]    x;
    logic [3:0]    nib;
    int            i;
    r.first_x = 9'(w.column) * 9'd7;
    r.line_y  = w.scanline;
    r.drawn   = !(m.mixed_mode && w.scanline >= TextLine);
    // run[i+1] is pixel i; run[0] and run[8] are the outer neighbors, zero at the row edges
    run = {w.next_byte[0] & (w.column < LastColumn), w.cur_byte[6:0],
           w.prev_byte[6] & (w.column != 6'd0)};
    nib = w.scanline[2] ? w.cur_byte[7:4] : w.cur_byte[3:0];
    for (i = 0; i < NumPix; i++) begin
      x = r.first_x + 9'(i);
      if (!r.drawn)
        r.colors[i] = '0;
      else if (!m.hires_select)
        r.colors[i] = LoresPalette[nib];
      else if (!run[i+1])
        r.colors[i] = ArgbBlack;
      else if (run[i] | run[i+2])
        r.colors[i] = ArgbWhite;
      else if (!w.cur_byte[7])
        r.colors[i] = x[0] ? ArgbGreen : ArgbPurple;
      else
        r.colors[i] = x[0] ? ArgbOrange : ArgbBlue;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  task automatic queue_pixel(logic [7:0] cur, logic [7:0] prev, logic [7:0] next,
                             logic [5:0] col, logic [7:0] line);
    source_word_t w;
    w = '{kind: KIND_PIXEL, cur_byte: cur, prev_byte: prev, next_byte: next,
          column: col, scanline: line, cfg_index: REG_HIRES_SELECT, cfg_data: 1'b0,
          idle_pct: gen_idle_pct};
    pending_words.push_back(w);
  endtask

  task automatic queue_mode(logic hires, logic mixed);
    source_word_t w;
    w = '{kind: KIND_CONFIG, cur_byte: '0, prev_byte: '0, next_byte: '0,
          column: '0, scanline: '0, cfg_index: REG_HIRES_SELECT, cfg_data: hires,
          idle_pct: 0};
    pending_words.push_back(w);
    w.cfg_index = REG_MIXED_MODE;
    w.cfg_data  = mixed;
    pending_words.push_back(w);
  endtask

  task automatic queue_random_pixel();
    logic [5:0] col;
    logic [7:0] line;
    col  = ($urandom_range(99) < 90) ? 6'($urandom_range(39)) : 6'($urandom_range(63, 40));
    line = ($urandom_range(99) < 85) ? 8'($urandom_range(191)) : 8'($urandom_range(255, 192));
    queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), col, line);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      quiet_cycles <= 0;
    end else if (start && busy) begin
      cfg_we <= 1'b0;
    end else begin
      send_pixel = 1'b0;
      send_cfg = 1'b0;
      if (pending_words.size() != 0) begin
        head_word = pending_words[0];
        if (head_word.kind == KIND_CONFIG)
          send_cfg = (quiet_cycles >= DrainCycles) && (expected_pixels.size() == 0);
        else
          send_pixel = $urandom_range(99) >= head_word.idle_pct;
      end
      start <= send_pixel;
      cfg_we <= send_cfg;
      quiet_cycles <= send_pixel ? 0 : quiet_cycles + 1;
      if (send_pixel || send_cfg) begin
        void'(pending_words.pop_front());
        cur_byte <= head_word.cur_byte;
        prev_byte <= head_word.prev_byte;
        next_byte <= head_word.next_byte;
        column <= head_word.column;
        scanline <= head_word.scanline;
        cfg_index <= head_word.cfg_index;
        cfg_data <= head_word.cfg_data;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_result_t want;
    source_word_t  seen;
    pix_row_t      got;
    int            i;
    if (rst) begin
      active_mode = '0;
    end else begin
      if (done) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display("%0t ns: result word expected none got first_x %h line_y %h",
                   $time, first_x, line_y);
        end else begin
          want = expected_pixels.pop_front();
          got = {color6, color5, color4, color3, color2, color1, color0};
          for (i = 0; i < NumPix; i++)
            check_field($sformatf("color%0d", i), want.colors[i], got[i]);
          check_field("first_x", 32'(want.first_x), 32'(first_x));
          check_field("line_y", 32'(want.line_y), 32'(line_y));
          check_field("drawn", 32'(want.drawn), 32'(drawn));
        end
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_HIRES_SELECT: active_mode.hires_select = cfg_data;
          REG_MIXED_MODE:   active_mode.mixed_mode = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        seen = '{kind: KIND_PIXEL, cur_byte: cur_byte, prev_byte: prev_byte,
                 next_byte: next_byte, column: column, scanline: scanline,
                 cfg_index: REG_HIRES_SELECT, cfg_data: 1'b0, idle_pct: 0};
        expected_pixels.push_back(colorize(seen, active_mode));
      end
    end
  end

  // watchdog: cycles in which no word moves
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WatchdogLimit) begin
      @(posedge clk);
      if (rst || (start && !busy) || done)
        stuck = 0;
      else
        stuck++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int idle_plan [3];
    int phase;
    int n;
    int k;
    idle_plan = '{38, 87, 0};
    gen_idle_pct = idle_plan[0];

    // hires: solid, white runs, isolated color bits, neighbors and row edges
    queue_mode(1'b1, 1'b0);
    queue_pixel(8'h00, 8'h00, 8'h00, 6'd0, 8'd0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 6'd0, 8'd0);
    queue_pixel(8'h7F, 8'h00, 8'h00, 6'd20, 8'd10);
    queue_pixel(8'h55, 8'h00, 8'h00, 6'd5, 8'd1);
    queue_pixel(8'hAA, 8'h00, 8'h00, 6'd6, 8'd2);
    queue_pixel(8'hD5, 8'h00, 8'h00, 6'd6, 8'd3);
    queue_pixel(8'h2A, 8'h00, 8'h00, 6'd5, 8'd4);
    queue_pixel(8'h01, 8'h40, 8'h00, 6'd1, 8'd5);
    queue_pixel(8'h40, 8'h00, 8'h01, 6'd7, 8'd6);
    queue_pixel(8'h40, 8'h00, 8'hFF, LastColumn, 8'd7);
    queue_pixel(8'h01, 8'hFF, 8'h00, 6'd0, 8'd8);
    queue_pixel(8'hC0, 8'hBF, 8'h01, 6'd63, 8'd255);

    // lores: both nibble halves across lines 0..7 of a block
    queue_mode(1'b0, 1'b0);
    for (k = 0; k < 8; k++)
      queue_pixel({4'(15 - k), 4'(k)}, 8'h00, 8'h00, 6'(k * 5), 8'(k * 9));

    // text area boundary
    queue_mode(1'b1, 1'b1);
    queue_pixel(8'hFF, 8'h00, 8'h00, 6'd10, 8'd159);
    queue_pixel(8'hFF, 8'h00, 8'h00, 6'd10, TextLine);
    queue_pixel(8'h55, 8'h00, 8'h00, 6'd10, 8'd191);
    queue_mode(1'b0, 1'b1);
    queue_pixel(8'h3C, 8'h00, 8'h00, 6'd12, TextLine);
    queue_pixel(8'h3C, 8'h00, 8'h00, 6'd12, 8'd255);
    queue_pixel(8'h3C, 8'h00, 8'h00, 6'd12, 8'd100);

    for (phase = 0; phase < 3; phase++) begin
      gen_idle_pct = idle_plan[phase];
      n = 0;
      while (n < 317) begin
        queue_mode(1'($urandom), 1'($urandom));
        for (k = $urandom_range(90, 40); k > 0 && n < 317; k--) begin
          queue_random_pixel();
          n++;
        end
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (expected_pixels.size() != 0) begin
      fail_count++;
      $display("%0t ns: %0d result words never arrived", $time, expected_pixels.size());
    end
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
